>>> src/sulnorm_pkg.sv
// shared types and defaults for the sorted unique list normalizer
package sulnorm_pkg;

	localparam int MAX_LIST_LEN_DEF = 32;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int OUT_WIDTH        = 32;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_DROP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

>>> src/sulnorm_cell.sv
// one cell of the sorting chain: sorted insert from the broadcast value, shift toward the head
module sulnorm_cell #(
	parameter int VALUE_WIDTH = sulnorm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sulnorm_pkg::cell_ctl_t   ctl,
	input  logic [VALUE_WIDTH-1:0]   ins_value,
	input  logic [VALUE_WIDTH-1:0]   prev_value,
	input  logic                     prev_valid,
	input  logic                     prev_gt,
	input  logic [VALUE_WIDTH-1:0]   next_value,
	input  logic                     next_valid,
	output logic [VALUE_WIDTH-1:0]   value,
	output logic                     valid,
	output logic                     gt
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   valid_q;
	logic                   keep;
	logic                   take_prev;
	logic                   take_new;

	assign gt        = valid_q && (value_q > ins_value);
	// a valid cell not above the new value stays where it is
	assign keep      = valid_q && !gt;
	assign take_prev = !keep && prev_gt;
	assign take_new  = !keep && !prev_gt && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.insert && (take_prev || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.insert && take_prev) begin
			value_q <= prev_value;
		end else if (ctl.insert && take_new) begin
			value_q <= ins_value;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

>>> src/sorted_unique_list_normalizer.sv
// top level: sorting chain of cells with the collect and emit sequencer
// list items are taken one per cycle while busy is low; each value enters the chain in that cycle
// after the last item: one cycle to skip the head when the list is full, then one cycle per held
// entry plus one to close, set by the chain draining one cell per cycle through its head
// results leave an output register one per cycle at most and must be taken when out_valid is high
// reset clears the chain valid bits, the entry count and the sequencer
module sorted_unique_list_normalizer #(
	parameter int MAX_LIST_LEN = sulnorm_pkg::MAX_LIST_LEN_DEF,
	parameter int VALUE_WIDTH  = sulnorm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [31:0]                       gap_value,
	input  logic                              has_value,
	input  logic                              last_in,
	output logic                              out_valid,
	output logic [sulnorm_pkg::OUT_WIDTH-1:0] out_value,
	output logic                              last_out
);

	localparam int CW = $clog2(MAX_LIST_LEN + 1);

	sulnorm_pkg::state_t    state_q, state_d;
	sulnorm_pkg::cell_ctl_t ctl;

	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          count_inc;
	logic [VALUE_WIDTH-1:0] pend_q, pend_d;
	logic [VALUE_WIDTH-1:0] ins_value;
	logic                   accept;
	logic                   do_insert;

	logic                   out_valid_q, out_valid_d;
	logic                   last_out_q, last_out_d;
	logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;

	logic [VALUE_WIDTH-1:0] val_w [MAX_LIST_LEN];
	logic                   vld_w [MAX_LIST_LEN];
	logic                   gt_w  [MAX_LIST_LEN];

	assign ins_value = VALUE_WIDTH'(gap_value);
	assign busy      = (state_q != sulnorm_pkg::ST_COLLECT);
	assign accept    = start && !busy;
	assign do_insert = accept && has_value && (count_q < CW'(MAX_LIST_LEN));
	assign count_inc = count_q + CW'(do_insert);

	for (genvar i = 0; i < MAX_LIST_LEN; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] pv, nv;
		logic                   pvld, pgt, nvld;

		if (i == 0) begin : g_head
			assign pv   = '0;
			assign pvld = 1'b1;
			assign pgt  = 1'b0;
		end else begin : g_body
			assign pv   = val_w[i-1];
			assign pvld = vld_w[i-1];
			assign pgt  = gt_w[i-1];
		end

		if (i == MAX_LIST_LEN - 1) begin : g_tail
			assign nv   = '0;
			assign nvld = 1'b0;
		end else begin : g_mid
			assign nv   = val_w[i+1];
			assign nvld = vld_w[i+1];
		end

		sulnorm_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.ins_value (ins_value),
			.prev_value(pv),
			.prev_valid(pvld),
			.prev_gt   (pgt),
			.next_value(nv),
			.next_valid(nvld),
			.value     (val_w[i]),
			.valid     (vld_w[i]),
			.gt        (gt_w[i])
		);
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pend_d      = pend_q;
		ctl.insert  = do_insert;
		ctl.shift   = 1'b0;
		out_valid_d = 1'b0;
		last_out_d  = 1'b0;
		out_value_d = out_value_q;
		unique case (state_q)
			sulnorm_pkg::ST_COLLECT: begin
				if (accept) begin
					count_d = count_inc;
					if (last_in) begin
						// every normalized list opens with 1
						count_d = '0;
						pend_d  = VALUE_WIDTH'(1);
						state_d = (count_inc == CW'(MAX_LIST_LEN)) ? sulnorm_pkg::ST_DROP
						                                           : sulnorm_pkg::ST_EMIT;
					end
				end
			end
			sulnorm_pkg::ST_DROP: begin
				// full list: the smallest entry gives way to the leading 1
				ctl.shift = 1'b1;
				state_d   = sulnorm_pkg::ST_EMIT;
			end
			sulnorm_pkg::ST_EMIT: begin
				if (vld_w[0]) begin
					ctl.shift = 1'b1;
					if (val_w[0] > pend_q) begin
						out_valid_d = 1'b1;
						out_value_d = pend_q;
						pend_d      = val_w[0];
					end
				end else begin
					out_valid_d = 1'b1;
					last_out_d  = 1'b1;
					out_value_d = pend_q;
					state_d     = sulnorm_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_d = sulnorm_pkg::ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sulnorm_pkg::ST_COLLECT;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			last_out_q  <= last_out_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q      <= pend_d;
		out_value_q <= out_value_d;
	end

	assign out_valid = out_valid_q;
	assign last_out  = last_out_q;
	assign out_value = sulnorm_pkg::OUT_WIDTH'(out_value_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LIST_LEN))
		else $error("entry count beyond capacity");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_out) |-> !busy)
		else $error("final result while the chain still drains");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_out) |-> busy)
		else $error("non-final result with no list in progress");

	a_drop_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sulnorm_pkg::ST_DROP) |=> (state_q == sulnorm_pkg::ST_EMIT))
		else $error("head skip not followed by emission");

endmodule
